### src/erlp_pkg.sv
// Shared types, codes and defaults for the expert page residency tracker.
// Used by erlp_ctrl, erlp_datapath and expert_residency_lru_prefetch.
`default_nettype none
package erlp_pkg;

  localparam int MAX_LAYERS_DEF     = 64;
  localparam int MAX_EXPERTS_DEF    = 64;
  localparam int RESIDENT_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF    = 16;

  localparam int ID_W    = 6;
  localparam int CFG_W   = 7;
  localparam int LIMIT_W = 5;
  localparam int TOTAL_W = 5;
  localparam int CNT_W   = 32;
  // wide enough for any slot count in range
  localparam int LIM_W   = 7;

  localparam logic [1:0] REG_LAYER_COUNT    = 2'd0;
  localparam logic [1:0] REG_EXPERT_COUNT   = 2'd1;
  localparam logic [1:0] REG_RESIDENT_LIMIT = 2'd2;

  localparam logic [1:0] OP_ACCESS   = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_SERVICE  = 2'd2;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_INVALID    = 3'd2,
    ST_QUEUED     = 3'd3,
    ST_NOT_QUEUED = 3'd4,
    ST_SERVICED   = 3'd5,
    ST_QUEUE_BAD  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT
  } state_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] layer;
    logic [ID_W-1:0] expert;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               evicted;
    logic [ID_W-1:0]    evicted_layer;
    logic [ID_W-1:0]    evicted_expert;
    logic [ID_W-1:0]    serviced_layer;
    logic [ID_W-1:0]    serviced_expert;
    logic [TOTAL_W-1:0] resident_total;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   eviction_total;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0] layer;
    logic [ID_W-1:0] expert;
  } page_t;

  typedef struct packed {
    logic    latch;
    logic    push;
    logic    pop;
    logic    refresh;
    logic    evict;
    logic    insert;
    logic    count_hit;
    logic    count_miss;
    logic    finish;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       id_ok;
    logic       resident;
    logic       q_empty;
    logic       q_full;
    logic       need_evict;
  } stat_t;

endpackage
`default_nettype wire

### src/erlp_ctrl.sv
// Sequencer for the residency tracker: decodes each transaction and steps
// the datapath through lookup, eviction and insertion. Uses erlp_pkg.
`default_nettype none
module erlp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire erlp_pkg::stat_t stat,
  output erlp_pkg::cmd_t      cmd
);

  erlp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erlp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != erlp_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = erlp_pkg::ST_INVALID;
    case (state)
      erlp_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = erlp_pkg::S_EXEC;
        end
      end
      erlp_pkg::S_EXEC: begin
        state_next = erlp_pkg::S_IDLE;
        cmd.finish = 1'b1;
        case (stat.operation)
          erlp_pkg::OP_ACCESS: begin
            if (!stat.id_ok) begin
              cmd.status = erlp_pkg::ST_INVALID;
            end else if (stat.resident) begin
              cmd.refresh   = 1'b1;
              cmd.count_hit = 1'b1;
              cmd.status    = erlp_pkg::ST_HIT;
            end else begin
              cmd.count_miss = 1'b1;
              cmd.finish     = 1'b0;
              state_next     = erlp_pkg::S_INSERT;
            end
          end
          erlp_pkg::OP_SCHEDULE: begin
            if (!stat.id_ok) begin
              cmd.status = erlp_pkg::ST_INVALID;
            end else if (stat.resident) begin
              cmd.status = erlp_pkg::ST_NOT_QUEUED;
            end else if (stat.q_full) begin
              cmd.status = erlp_pkg::ST_QUEUE_BAD;
            end else begin
              cmd.push   = 1'b1;
              cmd.status = erlp_pkg::ST_QUEUED;
            end
          end
          erlp_pkg::OP_SERVICE: begin
            if (stat.q_empty) begin
              cmd.status = erlp_pkg::ST_QUEUE_BAD;
            end else begin
              cmd.pop = 1'b1;
              if (stat.resident) begin
                cmd.refresh = 1'b1;
                cmd.status  = erlp_pkg::ST_SERVICED;
              end else begin
                cmd.finish = 1'b0;
                state_next = erlp_pkg::S_INSERT;
              end
            end
          end
          default: begin
            cmd.status = erlp_pkg::ST_INVALID;
          end
        endcase
      end
      erlp_pkg::S_INSERT: begin
        // drop one least-recent page per cycle until there is room
        if (stat.need_evict) begin
          cmd.evict = 1'b1;
        end else begin
          cmd.insert = 1'b1;
          cmd.finish = 1'b1;
          cmd.status = (stat.operation == erlp_pkg::OP_ACCESS) ?
                       erlp_pkg::ST_MISS : erlp_pkg::ST_SERVICED;
          state_next = erlp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = erlp_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/erlp_datapath.sv
// Datapath of the residency tracker: registers, LRU order cells, prefetch
// queue memory, counters and the result register. Uses erlp_pkg.
`default_nettype none
module erlp_datapath #(
  parameter int MAX_LAYERS     = erlp_pkg::MAX_LAYERS_DEF,
  parameter int MAX_EXPERTS    = erlp_pkg::MAX_EXPERTS_DEF,
  parameter int RESIDENT_SLOTS = erlp_pkg::RESIDENT_SLOTS_DEF,
  parameter int QUEUE_DEPTH    = erlp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [erlp_pkg::CFG_W-1:0]    cfg_data,
  input  wire erlp_pkg::request_t            request,
  input  wire erlp_pkg::cmd_t                cmd,
  output erlp_pkg::stat_t                    stat,
  output erlp_pkg::result_t                  result,
  output logic                               done
);

  localparam int FW = $clog2(RESIDENT_SLOTS + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = CW + 1;
  localparam int LW = erlp_pkg::LIM_W;
  localparam int IW = erlp_pkg::ID_W;

  logic [erlp_pkg::CFG_W-1:0]   layer_count;
  logic [erlp_pkg::CFG_W-1:0]   expert_count;
  logic [erlp_pkg::LIMIT_W-1:0] resident_limit;

  logic [1:0]       operation;
  erlp_pkg::page_t  in_page;
  erlp_pkg::page_t  q_rdata;
  erlp_pkg::page_t  cur_page;
  erlp_pkg::page_t  ev_page;
  logic             ev_flag;

  erlp_pkg::page_t  order      [RESIDENT_SLOTS];
  erlp_pkg::page_t  order_next [RESIDENT_SLOTS];
  logic [FW-1:0]    fill, fill_next;

  erlp_pkg::page_t  q_mem [QUEUE_DEPTH];
  logic [QW-1:0]    head;
  logic [CW-1:0]    qfill;
  logic [TW-1:0]    tail_sum;
  logic [TW-1:0]    tail;

  logic [erlp_pkg::CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;
  logic [erlp_pkg::CNT_W-1:0] hit_next, miss_next;

  logic [RESIDENT_SLOTS-1:0] match;
  logic [RESIDENT_SLOTS-1:0] after;
  logic [LW-1:0]             lim;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count    <= erlp_pkg::CFG_W'(64);
      expert_count   <= erlp_pkg::CFG_W'(64);
      resident_limit <= erlp_pkg::LIMIT_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        erlp_pkg::REG_LAYER_COUNT:    layer_count    <= cfg_data;
        erlp_pkg::REG_EXPERT_COUNT:   expert_count   <= cfg_data;
        erlp_pkg::REG_RESIDENT_LIMIT: resident_limit <= cfg_data[erlp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cur_page = (operation == erlp_pkg::OP_SERVICE) ? q_rdata : in_page;

  always_comb begin
    for (int j = 0; j < RESIDENT_SLOTS; j++) begin
      match[j] = (j < int'(fill)) && (order[j] == cur_page);
    end
    for (int j = 0; j < RESIDENT_SLOTS; j++) begin
      after[j] = |(match & ({RESIDENT_SLOTS{1'b1}} >> (RESIDENT_SLOTS - 1 - j)));
    end
  end

  always_comb begin
    if (resident_limit == '0) begin
      lim = LW'(1);
    end else if (int'(resident_limit) > RESIDENT_SLOTS) begin
      lim = LW'(RESIDENT_SLOTS);
    end else begin
      lim = LW'(resident_limit);
    end
  end

  always_comb begin
    stat.operation  = operation;
    stat.id_ok      = ({1'b0, in_page.layer} < layer_count) &&
                      (int'(in_page.layer) < MAX_LAYERS) &&
                      ({1'b0, in_page.expert} < expert_count) &&
                      (int'(in_page.expert) < MAX_EXPERTS);
    stat.resident   = |match;
    stat.q_empty    = (qfill == '0);
    stat.q_full     = (qfill == CW'(QUEUE_DEPTH));
    stat.need_evict = (LW'(fill) >= lim) && (fill != '0);
  end

  // LRU cells: index 0 is least recent
  always_comb begin
    fill_next = fill;
    for (int j = 0; j < RESIDENT_SLOTS; j++) begin
      order_next[j] = order[j];
    end
    if (cmd.evict) begin
      for (int j = 0; j < RESIDENT_SLOTS; j++) begin
        order_next[j] = order[(j < RESIDENT_SLOTS - 1) ? j + 1 : j];
      end
      fill_next = fill - FW'(1);
    end else if (cmd.refresh) begin
      for (int j = 0; j < RESIDENT_SLOTS; j++) begin
        if (j == int'(fill) - 1) begin
          order_next[j] = cur_page;
        end else if (after[j] && (j < int'(fill) - 1)) begin
          order_next[j] = order[(j < RESIDENT_SLOTS - 1) ? j + 1 : j];
        end
      end
    end else if (cmd.insert) begin
      for (int j = 0; j < RESIDENT_SLOTS; j++) begin
        if (j == int'(fill)) begin
          order_next[j] = cur_page;
        end
      end
      fill_next = fill + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RESIDENT_SLOTS; j++) begin
      order[j] <= order_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // queue
  always_comb begin
    tail_sum = TW'(head) + TW'(qfill);
    tail     = (tail_sum >= TW'(QUEUE_DEPTH)) ? tail_sum - TW'(QUEUE_DEPTH) : tail_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q_mem[tail[QW-1:0]] <= in_page;
    end
    if (cmd.latch) begin
      q_rdata <= q_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      qfill <= '0;
    end else if (cmd.push) begin
      qfill <= qfill + CW'(1);
    end else if (cmd.pop) begin
      head  <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
      qfill <= qfill - CW'(1);
    end
  end

  // latch the transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      operation      <= request.operation;
      in_page.layer  <= request.layer;
      in_page.expert <= request.expert;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ev_flag <= 1'b0;
      ev_page <= '0;
    end else if (cmd.evict) begin
      ev_flag <= 1'b1;
      ev_page <= order[0];
    end
  end

  assign hit_next  = hit_cnt + erlp_pkg::CNT_W'(cmd.count_hit);
  assign miss_next = miss_cnt + erlp_pkg::CNT_W'(cmd.count_miss);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else begin
      hit_cnt  <= hit_next;
      miss_cnt <= miss_next;
      if (cmd.evict) begin
        evict_cnt <= evict_cnt + erlp_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status          <= cmd.status;
      result.evicted         <= ev_flag;
      result.evicted_layer   <= ev_page.layer;
      result.evicted_expert  <= ev_page.expert;
      result.serviced_layer  <= (cmd.status == erlp_pkg::ST_SERVICED) ? q_rdata.layer  : IW'(0);
      result.serviced_expert <= (cmd.status == erlp_pkg::ST_SERVICED) ? q_rdata.expert : IW'(0);
      result.resident_total  <= erlp_pkg::TOTAL_W'(fill_next);
      result.hit_total       <= hit_next;
      result.miss_total      <= miss_next;
      result.eviction_total  <= evict_cnt;
    end
  end

endmodule
`default_nettype wire

### src/expert_residency_lru_prefetch.sv
// Top level of the expert page residency tracker with LRU replacement and
// a prefetch queue. Instantiates erlp_ctrl and erlp_datapath; uses erlp_pkg.
//
// Raise start with a request while busy is low; the request is taken at that
// edge. Each transaction yields one result, shown on result for one cycle with
// done high; it cannot be held off, so capture it then. A hit, schedule,
// invalid id or a service of a resident page ends in the execute state; a miss
// or a service that inserts goes on to the insert state, where the eviction
// loop drops one least-recent page per cycle until there is room, then inserts.
// The next request may be taken in the cycle the result is shown.
// Configuration writes are taken at any edge with cfg_write high and are
// meant to land only while idle.
`default_nettype none
module expert_residency_lru_prefetch #(
  parameter int MAX_LAYERS     = erlp_pkg::MAX_LAYERS_DEF,
  parameter int MAX_EXPERTS    = erlp_pkg::MAX_EXPERTS_DEF,
  parameter int RESIDENT_SLOTS = erlp_pkg::RESIDENT_SLOTS_DEF,
  parameter int QUEUE_DEPTH    = erlp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [erlp_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       start,
  output logic                            busy,
  input  wire erlp_pkg::request_t         request,
  output erlp_pkg::result_t               result,
  output logic                            done
);

  erlp_pkg::cmd_t  cmd;
  erlp_pkg::stat_t stat;

  erlp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  erlp_datapath #(
    .MAX_LAYERS     (MAX_LAYERS),
    .MAX_EXPERTS    (MAX_EXPERTS),
    .RESIDENT_SLOTS (RESIDENT_SLOTS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(result.resident_total) <= RESIDENT_SLOTS))
    else $error("resident total above slot count");
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.evicted |-> (result.evicted_layer == '0) &&
      (result.evicted_expert == '0))
    else $error("eviction fields set without eviction");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking bench for expert_residency_lru_prefetch: a queue-fed driver,
// a monitor with an in-bench LRU/prefetch predictor, and phased config writes.
// Depends on erlp_pkg and the top level in src.
module tb;

  localparam int SLOTS = erlp_pkg::RESIDENT_SLOTS_DEF;
  localparam int QDEPTH = erlp_pkg::QUEUE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  // operation code with no meaning, answered as an invalid id
  localparam logic [1:0] OP_BAD = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = erlp_pkg::REG_LAYER_COUNT;
  logic [erlp_pkg::CFG_W-1:0] cfg_data = '0;
  logic start = 0;
  logic busy;
  erlp_pkg::request_t request = '0;
  erlp_pkg::result_t result;
  logic done;

  expert_residency_lru_prefetch dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .request(request),
    .result(result), .done(done)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  logic [6:0] layer_cnt = 7'd64;
  logic [6:0] expert_cnt = 7'd64;
  logic [4:0] limit_reg = 5'd16;
  bit resident [0:4095];
  erlp_pkg::page_t lru [0:SLOTS-1];
  int lru_fill = 0;
  erlp_pkg::page_t pf_queue [0:QDEPTH-1];
  int q_head = 0;
  int q_fill = 0;
  logic [31:0] hits = 0, misses = 0, evictions = 0;
  bit ev_flag;
  erlp_pkg::page_t ev_last;

  erlp_pkg::request_t pending_items [$];
  erlp_pkg::result_t expected_results [$];
  int issued = 0;
  int taken_total = 0;
  int errors = 0;
  int cycles = 0;
  int serviced_seen = 0;

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cycles, got, want);
  endtask

  task automatic cmp(string field, longint got, longint want);
    if (got != want) report(field, got, want);
  endtask

  function automatic int pidx(erlp_pkg::page_t p);
    return p.layer * 64 + p.expert;
  endfunction

  task automatic drop_at(int pos);
    for (int i = pos; i + 1 < lru_fill; i++) lru[i] = lru[i+1];
    lru_fill--;
  endtask

  task automatic insert_page(erlp_pkg::page_t p);
    int lim;
    erlp_pkg::page_t v;
    lim = (limit_reg == 0) ? 1 : (limit_reg > SLOTS ? SLOTS : limit_reg);
    while (lru_fill >= lim && lru_fill > 0) begin
      v = lru[0];
      drop_at(0);
      resident[pidx(v)] = 0;
      evictions++;
      ev_flag = 1;
      ev_last = v;
    end
    if (lru_fill < SLOTS) begin
      lru[lru_fill] = p;
      lru_fill++;
    end
    resident[pidx(p)] = 1;
  endtask

  task automatic refresh_page(erlp_pkg::page_t p);
    for (int i = 0; i < lru_fill; i++) begin
      if (lru[i] == p) begin
        drop_at(i);
        lru[lru_fill] = p;
        lru_fill++;
        return;
      end
    end
  endtask

  task automatic predict_result(erlp_pkg::request_t rq);
    erlp_pkg::result_t r;
    erlp_pkg::page_t p, sv;
    bit ok;
    r = '0;
    p.layer = rq.layer;
    p.expert = rq.expert;
    sv = '0;
    ev_flag = 0;
    ev_last = '0;
    ok = rq.layer < layer_cnt && rq.expert < expert_cnt;
    r.status = erlp_pkg::ST_INVALID;
    case (rq.operation)
      erlp_pkg::OP_ACCESS: begin
        if (ok) begin
          if (resident[pidx(p)]) begin
            hits++;
            refresh_page(p);
            r.status = erlp_pkg::ST_HIT;
          end else begin
            misses++;
            insert_page(p);
            r.status = erlp_pkg::ST_MISS;
          end
        end
      end
      erlp_pkg::OP_SCHEDULE: begin
        if (ok) begin
          if (resident[pidx(p)]) r.status = erlp_pkg::ST_NOT_QUEUED;
          else if (q_fill >= QDEPTH) r.status = erlp_pkg::ST_QUEUE_BAD;
          else begin
            pf_queue[(q_head + q_fill) % QDEPTH] = p;
            q_fill++;
            r.status = erlp_pkg::ST_QUEUED;
          end
        end
      end
      erlp_pkg::OP_SERVICE: begin
        if (q_fill == 0) r.status = erlp_pkg::ST_QUEUE_BAD;
        else begin
          sv = pf_queue[q_head];
          q_head = (q_head + 1) % QDEPTH;
          q_fill--;
          if (resident[pidx(sv)]) refresh_page(sv);
          else insert_page(sv);
          r.status = erlp_pkg::ST_SERVICED;
        end
      end
      default: ;
    endcase
    r.evicted = ev_flag;
    r.evicted_layer = ev_last.layer;
    r.evicted_expert = ev_last.expert;
    r.serviced_layer = sv.layer;
    r.serviced_expert = sv.expert;
    r.resident_total = lru_fill[erlp_pkg::TOTAL_W-1:0];
    r.hit_total = hits;
    r.miss_total = misses;
    r.eviction_total = evictions;
    expected_results = {expected_results, r};
  endtask

  // monitor: check results, then record the accepted transaction and config writes
  always @(posedge clk) begin
    erlp_pkg::result_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) report("unexpected result", result.status, -1);
        else begin
          w = expected_results.pop_front();
          cmp("status", result.status, w.status);
          cmp("evicted", result.evicted, w.evicted);
          cmp("evicted_layer", result.evicted_layer, w.evicted_layer);
          cmp("evicted_expert", result.evicted_expert, w.evicted_expert);
          cmp("serviced_layer", result.serviced_layer, w.serviced_layer);
          cmp("serviced_expert", result.serviced_expert, w.serviced_expert);
          cmp("resident_total", result.resident_total, w.resident_total);
          cmp("hit_total", result.hit_total, w.hit_total);
          cmp("miss_total", result.miss_total, w.miss_total);
          cmp("eviction_total", result.eviction_total, w.eviction_total);
          if (w.status == erlp_pkg::ST_SERVICED) serviced_seen++;
        end
      end
      if (start && !busy) begin
        predict_result(request);
        taken_total++;
      end
      if (cfg_write) begin
        case (cfg_index)
          erlp_pkg::REG_LAYER_COUNT: layer_cnt = cfg_data;
          erlp_pkg::REG_EXPERT_COUNT: expert_cnt = cfg_data;
          erlp_pkg::REG_RESIDENT_LIMIT: limit_reg = cfg_data[erlp_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (start && taken_total != issued) begin
      // hold until taken
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 0;
    end else if (pending_items.size() > 0) begin
      request <= pending_items.pop_front();
      start <= 1;
      issued++;
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 1) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      end
    end else begin
      start <= 0;
    end
  end

  task automatic add(logic [1:0] op, int l, int e);
    erlp_pkg::request_t rq;
    rq.operation = op;
    rq.layer = erlp_pkg::ID_W'(l);
    rq.expert = erlp_pkg::ID_W'(e);
    pending_items = {pending_items, rq};
  endtask

  task automatic add_random(int n, int span);
    int k;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      op = k < 42 ? erlp_pkg::OP_ACCESS :
           (k < 70 ? erlp_pkg::OP_SCHEDULE : (k < 95 ? erlp_pkg::OP_SERVICE : OP_BAD));
      if ($urandom_range(0, 9) == 0) add(op, $urandom_range(0, 63), $urandom_range(0, 63));
      else add(op, $urandom_range(0, span), $urandom_range(0, span));
    end
  endtask

  task automatic settle();
    while (!(pending_items.size() == 0 && issued == taken_total &&
             expected_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= erlp_pkg::CFG_W'(val);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic set_all(int lc, int ec, int lim);
    settle();
    write_cfg(erlp_pkg::REG_LAYER_COUNT, lc);
    write_cfg(erlp_pkg::REG_EXPERT_COUNT, ec);
    write_cfg(erlp_pkg::REG_RESIDENT_LIMIT, lim);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: hit/miss, extremes, duplicate schedule, empty service, bad op
    add(erlp_pkg::OP_ACCESS, 0, 0);
    add(erlp_pkg::OP_ACCESS, 0, 0);
    add(erlp_pkg::OP_ACCESS, 63, 63);
    add(erlp_pkg::OP_SCHEDULE, 1, 1);
    add(erlp_pkg::OP_SCHEDULE, 1, 1);
    add(erlp_pkg::OP_SCHEDULE, 0, 0);
    add(erlp_pkg::OP_SERVICE, 0, 0);
    add(erlp_pkg::OP_SERVICE, 0, 0);
    add(erlp_pkg::OP_SERVICE, 0, 0);
    add(OP_BAD, 42, 21);
    for (int i = 0; i < 17; i++) add(erlp_pkg::OP_SCHEDULE, 2 + i, 5);
    settle();
    for (int i = 0; i < 16; i++) add(erlp_pkg::OP_SERVICE, 0, 0);
    add_random(120, 7);

    // small id space, small limit; invalid ids and evictions
    set_all(4, 4, 3);
    add(erlp_pkg::OP_ACCESS, 5, 0);
    add(erlp_pkg::OP_SCHEDULE, 0, 9);
    add(erlp_pkg::OP_ACCESS, 3, 3);
    add_random(150, 5);

    // limit lowered under a full order, then clamp to one
    set_all(64, 64, 16);
    for (int i = 0; i < 16; i++) add(erlp_pkg::OP_ACCESS, i, 1);
    add_random(60, 20);
    set_all(64, 64, 2);
    add(erlp_pkg::OP_ACCESS, 15, 1);
    add(erlp_pkg::OP_ACCESS, 40, 40);
    add_random(100, 6);
    set_all(127, 127, 0);
    add_random(120, 4);
    set_all(8, 8, 31);
    add_random(150, 9);
    set_all(0, 0, 5);
    add_random(30, 3);
    set_all(1, 64, 1);
    add_random(60, 3);
    set_all(64, 64, 16);
    add_random(50, 12);

    settle();
    $display("ran %0d transactions: %0d hits, %0d misses, %0d evictions, %0d services",
             taken_total, hits, misses, evictions, serviced_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
